/* rtl/rcs_pkg.sv */
// Shared widths, constants and types of the reflectance calibration and scaling block.
package rcs_pkg;

	// Field and datapath widths.
	localparam int RAW_W   = 15;
	localparam int SPAN_W  = 16;
	localparam int LEVEL_W = 10;
	localparam int PROD_W  = 25;
	localparam int CNT_W   = $clog2(PROD_W);
	localparam int BATCH_W = 4;
	localparam int OP_W    = 2;

	// Reset values and scale constants.
	localparam logic [RAW_W-1:0]   TIMEOUT_RESET  = 15'd2500;
	localparam logic [RAW_W-1:0]   MIN_RESET      = 15'h7FFF;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL     = 10'd1000;
	localparam int                 BATCH_SIZE_DEF = 10;

	// Operation carried with each input beat.
	typedef enum logic [OP_W-1:0] {
		OP_CAL  = 2'd0,
		OP_MEAS = 2'd1,
		OP_CLR  = 2'd2
	} op_t;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

endpackage

/* rtl/reflectance_calibrate_scale_top.sv */
// Top level of the reflectance calibration and scaling block.
//
// Input beats arrive on the s_axis channel: tuser carries the operation
// (calibration reading, measurement or calibration reset) and tdata the raw
// discharge time, which is first saturated to the timeout register.
// Calibration readings and resets update the stored limits and produce no
// output beat.
// A measurement produces one beat on m_axis: tdata holds the level 0..1000
// and tuser the calibrated flag. After acceptance the operands are captured,
// the difference is multiplied by 1000 and divided by the span in the radix-2
// divider, and the quotient is clamped and loaded into the output register.
// A measurement whose level is zero without a division (no valid calibration,
// zero span, or a reading at or below the minimum) skips the divider.
// s_axis_tready is low while a measurement is in flight and rises as its result
// is loaded, so no new beat is taken before a measurement is through.
// A finished result waits in the output register; if the receiver stalls,
// a further measurement may proceed but holds at its end until it frees.
// The timeout register is to be written through cfg_we/cfg_wdata while idle;
// the block does not enforce this. Reset clears calibration (marked invalid),
// the batch counter and the output valid flag, and loads the timeout with 2500.
module reflectance_calibrate_scale_top #(
	parameter int BATCH_SIZE = rcs_pkg::BATCH_SIZE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration: timeout register.
	input  logic                      cfg_we,
	input  logic [rcs_pkg::RAW_W-1:0] cfg_wdata,
	// Input beats.
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [15:0]               s_axis_tdata,  // [14:0] raw_time, [15] zero
	input  logic [rcs_pkg::OP_W-1:0]  s_axis_tuser,  // [1:0] op
	// Result beats.
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [15:0]               m_axis_tdata,  // [9:0] level, [15:10] zero
	output logic                      m_axis_tuser   // [0] calibrated
);

	localparam int RW = rcs_pkg::RAW_W;
	localparam int SW = rcs_pkg::SPAN_W;
	localparam int LW = rcs_pkg::LEVEL_W;
	localparam int PW = rcs_pkg::PROD_W;
	localparam int BW = rcs_pkg::BATCH_W;

	rcs_pkg::state_t state_q;

	logic [RW-1:0] timeout_q;
	logic [RW-1:0] cal_max_q;
	logic [RW-1:0] cal_min_q;
	logic          cal_valid_q;
	logic [BW-1:0] batch_cnt_q;
	logic [RW-1:0] batch_low_q;
	logic [RW-1:0] batch_high_q;

	logic [RW-1:0] diff_q;
	logic [SW-1:0] span_q;
	logic          zero_q;
	logic          meas_cal_q;

	logic          out_valid_q;
	logic [LW-1:0] out_level_q;
	logic          out_cal_q;

	logic          in_acc;
	rcs_pkg::op_t  in_op;
	logic [RW-1:0] raw_in;
	logic [RW-1:0] raw_sat;
	logic [SW-1:0] span;
	logic [RW-1:0] new_low;
	logic [RW-1:0] new_high;
	logic [BW-1:0] cnt_next;
	logic          batch_end;

	logic          div_start;
	logic          div_done;
	logic [PW-1:0] dividend;
	logic [PW-1:0] quotient;
	logic [LW-1:0] level_fin;
	logic          out_free;

	// Input decode and saturation to the timeout.
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign in_op   = rcs_pkg::op_t'(s_axis_tuser);
	assign raw_in  = s_axis_tdata[RW-1:0];
	assign raw_sat = (raw_in > timeout_q) ? timeout_q : raw_in;
	assign span    = {1'b0, cal_max_q} - {1'b0, cal_min_q};

	// Running batch extremes and end-of-batch detection.
	assign new_low   = (batch_cnt_q == '0 || raw_sat < batch_low_q) ? raw_sat : batch_low_q;
	assign new_high  = (batch_cnt_q == '0 || raw_sat > batch_high_q) ? raw_sat : batch_high_q;
	assign cnt_next  = batch_cnt_q + 1'b1;
	assign batch_end = (cnt_next >= BW'(BATCH_SIZE)) || (cnt_next == '0);

	assign s_axis_tready = (state_q == rcs_pkg::S_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rcs_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Calibration state: limits, valid flag and batch counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_max_q   <= '0;
			cal_min_q   <= rcs_pkg::MIN_RESET;
			cal_valid_q <= 1'b0;
			batch_cnt_q <= '0;
		end else if (in_acc) begin
			unique case (in_op)
				rcs_pkg::OP_CAL: begin
					batch_cnt_q <= cnt_next;
					if (batch_end) begin
						batch_cnt_q <= '0;
						if (new_low > cal_max_q) cal_max_q <= new_low;
						if (new_high < cal_min_q) cal_min_q <= new_high;
					end
				end
				rcs_pkg::OP_CLR: begin
					cal_max_q   <= '0;
					cal_min_q   <= timeout_q;
					cal_valid_q <= 1'b1;
					batch_cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Batch extremes and measurement operands.
	always_ff @(posedge clk) begin
		if (in_acc && in_op == rcs_pkg::OP_CAL) begin
			batch_low_q  <= new_low;
			batch_high_q <= new_high;
		end
		if (in_acc && in_op == rcs_pkg::OP_MEAS) begin
			diff_q     <= raw_sat - cal_min_q;
			span_q     <= span;
			zero_q     <= !cal_valid_q || span == '0 || raw_sat <= cal_min_q;
			meas_cal_q <= cal_valid_q;
		end
	end

	// Sequencer for measurements.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcs_pkg::S_IDLE;
		end else begin
			unique case (state_q)
				rcs_pkg::S_IDLE: begin
					if (in_acc && in_op == rcs_pkg::OP_MEAS) state_q <= rcs_pkg::S_MUL;
				end
				rcs_pkg::S_MUL: begin
					state_q <= zero_q ? rcs_pkg::S_FIN : rcs_pkg::S_DIV;
				end
				rcs_pkg::S_DIV: begin
					if (div_done) state_q <= rcs_pkg::S_FIN;
				end
				rcs_pkg::S_FIN: begin
					if (out_free) state_q <= rcs_pkg::S_IDLE;
				end
				default: begin
					state_q <= rcs_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Scaled numerator into the divider.
	assign div_start = (state_q == rcs_pkg::S_MUL) && !zero_q;
	assign dividend  = PW'(diff_q) * PW'(rcs_pkg::LEVEL_FULL);

	rcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Clamp the quotient to full scale.
	assign level_fin = zero_q ? '0 :
		(quotient > PW'(rcs_pkg::LEVEL_FULL)) ? rcs_pkg::LEVEL_FULL : quotient[LW-1:0];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rcs_pkg::S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rcs_pkg::S_FIN && out_free) begin
			out_level_q <= level_fin;
			out_cal_q   <= meas_cal_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(16 - LW){1'b0}}, out_level_q};
	assign m_axis_tuser  = out_cal_q;

	// A result never exceeds full scale.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_level_q <= rcs_pkg::LEVEL_FULL)
		else $error("level above full scale");

	// Without valid calibration the level is zero.
	a_uncal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !out_cal_q) |-> out_level_q == '0)
		else $error("uncalibrated result with nonzero level");

	// The divider only finishes while the sequencer waits for it.
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == rcs_pkg::S_DIV)
		else $error("divider finished outside the divide state");

	// A measurement closes the input until its result is loaded.
	a_meas_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_op == rcs_pkg::OP_MEAS) |=> !s_axis_tready)
		else $error("input open during a measurement");

	// The batch counter never reaches the batch size.
	a_batch_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		32'(batch_cnt_q) < BATCH_SIZE)
		else $error("batch counter out of range");

endmodule

/* rtl/rcs_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module rcs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rcs_pkg::PROD_W-1:0] dividend,
	input  logic [rcs_pkg::SPAN_W-1:0] divisor,
	output logic                       done,
	output logic [rcs_pkg::PROD_W-1:0] quotient
);

	localparam int QW = rcs_pkg::PROD_W;
	localparam int DW = rcs_pkg::SPAN_W;
	localparam int CW = rcs_pkg::CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [QW-1:0] quo_q;

	logic [DW:0]   trial;
	logic          fits;

	// Shift the next dividend bit into the partial remainder and try the subtraction.
	assign trial = {rem_q, quo_q[QW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// Control: count quotient bits and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
